>>> rtl/weighted_window_smoother_with_slope_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted window smoother
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_WINDOW_SMOOTHER_WITH_SLOPE_MACROS_SVH
`define WEIGHTED_WINDOW_SMOOTHER_WITH_SLOPE_MACROS_SVH

// same-cycle implication
`define WWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wws_pkg.sv
// ----------------------------------------------------------------------------
// wws_pkg
// Shared types and constants of the weighted window smoother.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wws_pkg;

  // stream data is padded to whole bytes
  localparam int BYTE_W = 8;

  // per-cell control: shift a new sample in, or rotate the ring by one
  typedef struct packed {
    logic shift;
    logic rot;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/weighted_window_smoother_with_slope.sv
// ----------------------------------------------------------------------------
// weighted_window_smoother_with_slope
// Edge-replicating weighted window smoother over a block of samples, with
// the first difference of consecutive results.
// ----------------------------------------------------------------------------
// Sequence: a request that causes a result starts a ring pass at one tap per
//   cycle, then the newest- and oldest-edge fix-ups, the MAC drain and the
//   reciprocal divide; each flushed result of a finished block repeats this.
// Input: a request that causes no result leaves in_tready high; one that causes
//   a result holds the input until its last result is loaded, which waits on out_tready.
// Reset: synchronous, active low; clears control and valids, ring left undefined.
`timescale 1ns / 1ps
`default_nettype none

module weighted_window_smoother_with_slope
  import wws_pkg::*;
#(
  parameter int WINDOW_LEN   = 51,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,

  input  logic in_tvalid,
  output logic in_tready,
  // [SAMPLE_WIDTH-1:0] sample, rest zero
  input  logic [((SAMPLE_WIDTH+BYTE_W-1)/BYTE_W)*BYTE_W-1:0] in_tdata,
  input  logic in_tlast,  // block_end

  output logic out_tvalid,
  input  logic out_tready,
  // [SAMPLE_WIDTH-1:0] smoothed, [2*SAMPLE_WIDTH:SAMPLE_WIDTH] slope, rest zero
  output logic [((2*SAMPLE_WIDTH+1+BYTE_W-1)/BYTE_W)*BYTE_W-1:0] out_tdata,
  output logic out_tlast  // final_output
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int H      = (WINDOW_LEN - 1) / 2;          // half window
  localparam int TAPS   = 2 * H + 1;                     // taps in use
  localparam int SW     = SAMPLE_WIDTH;
  localparam int WSUM   = TAPS + H * (H + 1) * (2 * H + 1) / 3;  // sum of 1+k+k^2
  localparam int WW     = $clog2(WSUM + 1);              // weight bits
  localparam int AW     = SW + WW;                       // accumulator bits
  localparam int JW     = $clog2(TAPS);                  // tap counter
  localparam int KW     = JW + 2;                        // signed tap offsets
  localparam int FW     = $clog2(TAPS + 1);              // fill count
  localparam int DW     = $clog2(H + 1);                 // output distance
  localparam int OUT_DW = ((2 * SW + 1 + BYTE_W - 1) / BYTE_W) * BYTE_W;

  localparam logic signed [KW-1:0]  H_S   = KW'(H);
  localparam logic signed [KW-1:0]  NEG_H = -H_S;
  localparam logic signed [KW-1:0]  ONE_K = KW'(1);
  localparam logic signed [2*KW:0]  ONE_T = (2 * KW + 1)'(1);
  localparam logic [AW-1:0]         HALF_SUM = AW'(WSUM / 2);

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;  // taking requests
  localparam logic [3:0] ST_RUN    = 4'd1;  // one tap per cycle round the ring
  localparam logic [3:0] ST_FIX0   = 4'd2;  // newest-edge weight
  localparam logic [3:0] ST_FIX1   = 4'd3;  // oldest-edge weight
  localparam logic [3:0] ST_DRAIN0 = 4'd4;
  localparam logic [3:0] ST_DRAIN1 = 4'd5;
  localparam logic [3:0] ST_DSTART = 4'd6;  // launch divider
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;  // hand result to output register

  // weight of tap offset m: 1 + m + m^2
  function automatic logic [WW-1:0] wfun(input logic signed [KW-1:0] m);
    logic signed [2*KW:0] me;
    logic signed [2*KW:0] t;
    me = (2 * KW + 1)'(m);
    t  = me * me + me + ONE_T;
    return WW'(t);
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [3:0]           state_r, state_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [DW-1:0]        d_r, d_nxt;         // distance of output behind newest
  logic                 end_r, end_nxt;     // flushing a finished block
  logic [JW-1:0]        j_r, j_nxt;         // ring position

  logic signed [SW-1:0] x0_r, x0_nxt;       // newest sample, captured in pass
  logic signed [SW-1:0] xo_r, xo_nxt;       // oldest valid sample
  logic [WW-1:0]        whi_r, whi_nxt;     // weight folded onto newest
  logic [WW-1:0]        wlo_r, wlo_nxt;     // weight folded onto oldest

  logic signed [SW-1:0] xa_r, xa_nxt;       // MAC operand stage
  logic [WW-1:0]        wa_r, wa_nxt;
  logic                 va_r, va_nxt;
  logic signed [AW-1:0] prod_r, prod_nxt;   // product stage
  logic                 vb_r, vb_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;

  logic signed [SW-1:0] prev_r, prev_nxt;
  logic                 started_r, started_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [SW-1:0]        out_sm_r, out_sm_nxt;
  logic [SW:0]          out_sl_r, out_sl_nxt;
  logic                 out_last_r, out_last_nxt;

  // --------------------------------------------------------------------------
  // Delay ring: shifts on a request, rotates towards the head during a pass
  // --------------------------------------------------------------------------
  cell_ctl_t            cell_ctl;
  logic signed [SW-1:0] cell_q [TAPS];
  logic signed [SW-1:0] in_sample;
  logic signed [SW-1:0] head;
  logic                 in_acc;

  assign in_tready     = (state_r == ST_IDLE);
  assign in_acc        = in_tvalid && in_tready;
  assign in_sample     = $signed(in_tdata[SW-1:0]);
  assign cell_ctl.shift = in_acc;
  assign cell_ctl.rot   = (state_r == ST_RUN);
  assign head          = cell_q[0];

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    localparam int NXT = (i + 1) % TAPS;
    logic signed [SW-1:0] prev_in;
    if (i == 0) begin : g_head
      assign prev_in = in_sample;
    end else begin : g_body
      assign prev_in = cell_q[i-1];
    end
    wws_cell #(
      .SW (SW)
    ) u_cell (
      .clk    (clk),
      .ctl    (cell_ctl),
      .prev_i (prev_in),
      .next_i (cell_q[NXT]),
      .q_o    (cell_q[i])
    );
  end

  // --------------------------------------------------------------------------
  // Tap weights at ring position j. Slot j carries tap k = d - j for
  // j <= oldest; taps beyond the newest edge fold onto slot 0 and taps past
  // the oldest sample fold onto the oldest slot (edge replication).
  // --------------------------------------------------------------------------
  logic [FW-1:0]        oldest;
  logic [FW-1:0]        fill_inc;
  logic signed [KW-1:0] d_s, j_s, o_s;
  logic signed [KW-1:0] k0, m_hi, m_lo;
  logic                 a_in, hi_in, lo_in;

  assign oldest = fill_r - FW'(1);
  assign d_s    = $signed(KW'(d_r));
  assign j_s    = $signed(KW'(j_r));
  assign o_s    = $signed(KW'(oldest));
  assign k0     = d_s - j_s;
  assign m_hi   = d_s + ONE_K + j_s;
  assign m_lo   = d_s - o_s - ONE_K - j_s;
  assign a_in   = (FW'(j_r) <= oldest) && (k0 >= NEG_H);
  assign hi_in  = (m_hi <= H_S);
  assign lo_in  = (m_lo >= NEG_H);
  assign fill_inc = (fill_r == FW'(TAPS)) ? fill_r : fill_r + FW'(1);

  // --------------------------------------------------------------------------
  // Rounding divider: |acc| + WSUM/2 over WSUM, sign restored afterwards
  // --------------------------------------------------------------------------
  logic [AW-1:0]  acc_abs, div_in;
  logic           div_start, div_busy;
  logic [SW-1:0]  quot;
  logic [SW-1:0]  sm_v;
  logic [SW:0]    sl_v;
  logic           last_v;

  assign acc_abs   = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
  assign div_in    = acc_abs + HALF_SUM;
  assign div_start = (state_r == ST_DSTART);

  wws_div #(
    .QW      (SW),
    .RW      (WW),
    .DIVISOR (WSUM)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_in),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign sm_v   = neg_r ? SW'(-quot) : quot;
  assign sl_v   = started_r ? ($signed({sm_v[SW-1], sm_v}) - $signed({prev_r[SW-1], prev_r}))
                            : '0;
  assign last_v = end_r && (d_r == '0);

  // --------------------------------------------------------------------------
  // Sequencer and datapath
  // --------------------------------------------------------------------------
  logic run_go;  // start a new pass

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    d_nxt         = d_r;
    end_nxt       = end_r;
    j_nxt         = j_r;
    x0_nxt        = x0_r;
    xo_nxt        = xo_r;
    whi_nxt       = whi_r;
    wlo_nxt       = wlo_r;
    xa_nxt        = xa_r;
    wa_nxt        = wa_r;
    va_nxt        = 1'b0;
    prod_nxt      = prod_r;
    vb_nxt        = va_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    prev_nxt      = prev_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    out_sm_nxt    = out_sm_r;
    out_sl_nxt    = out_sl_r;
    out_last_nxt  = out_last_r;
    run_go        = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // product and accumulate stages
    if (va_r) begin
      prod_nxt = AW'(xa_r) * AW'($signed({1'b0, wa_r}));
    end
    if (vb_r) begin
      acc_nxt = acc_r + prod_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          fill_nxt = fill_inc;
          if (in_tlast) begin
            end_nxt = 1'b1;
            d_nxt   = ((fill_inc - FW'(1)) < FW'(H)) ? DW'(fill_inc - FW'(1)) : DW'(H);
            run_go  = 1'b1;
          end else if (fill_inc >= FW'(H + 1)) begin
            end_nxt = 1'b0;
            d_nxt   = DW'(H);
            run_go  = 1'b1;
          end
        end
      end
      ST_RUN: begin
        xa_nxt = a_in ? head : '0;
        wa_nxt = a_in ? wfun(k0) : '0;
        va_nxt = 1'b1;
        if (j_r == '0) begin
          x0_nxt = head;
        end
        if (FW'(j_r) == oldest) begin
          xo_nxt = head;
        end
        if (hi_in) begin
          whi_nxt = whi_r + wfun(m_hi);
        end
        if (lo_in) begin
          wlo_nxt = wlo_r + wfun(m_lo);
        end
        if (j_r == JW'(TAPS - 1)) begin
          state_nxt = ST_FIX0;
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
      ST_FIX0: begin
        xa_nxt    = x0_r;
        wa_nxt    = whi_r;
        va_nxt    = 1'b1;
        state_nxt = ST_FIX1;
      end
      ST_FIX1: begin
        xa_nxt    = xo_r;
        wa_nxt    = wlo_r;
        va_nxt    = 1'b1;
        state_nxt = ST_DRAIN0;
      end
      ST_DRAIN0: begin
        state_nxt = ST_DRAIN1;
      end
      ST_DRAIN1: begin
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        neg_nxt   = acc_r[AW-1];
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sm_nxt    = sm_v;
          out_sl_nxt    = sl_v;
          out_last_nxt  = last_v;
          prev_nxt      = $signed(sm_v);
          started_nxt   = 1'b1;
          if (end_r && (d_r != '0)) begin
            d_nxt  = d_r - DW'(1);
            run_go = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
            if (end_r) begin
              // block closed: next request opens a new one
              fill_nxt    = '0;
              prev_nxt    = '0;
              started_nxt = 1'b0;
              end_nxt     = 1'b0;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (run_go) begin
      state_nxt = ST_RUN;
      j_nxt     = '0;
      acc_nxt   = '0;
      whi_nxt   = '0;
      wlo_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      d_r         <= '0;
      end_r       <= 1'b0;
      j_r         <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      prev_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      d_r         <= d_nxt;
      end_r       <= end_nxt;
      j_r         <= j_nxt;
      va_r        <= va_nxt;
      vb_r        <= vb_nxt;
      prev_r      <= prev_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r       <= x0_nxt;
    xo_r       <= xo_nxt;
    whi_r      <= whi_nxt;
    wlo_r      <= wlo_nxt;
    xa_r       <= xa_nxt;
    wa_r       <= wa_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    out_sm_r   <= out_sm_nxt;
    out_sl_r   <= out_sl_nxt;
    out_last_r <= out_last_nxt;
  end

  // --------------------------------------------------------------------------
  // Output register drives the result channel directly
  // --------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW - 2 * SW - 1){1'b0}}, out_sl_r, out_sm_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> rtl/wws_cell.sv
// ----------------------------------------------------------------------------
// wws_cell
// One sample slot of the delay ring; loads from either neighbour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wws_cell
  import wws_pkg::*;
#(
  parameter int SW = 16
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic signed [SW-1:0] prev_i,  // newer neighbour (shift direction)
  input  logic signed [SW-1:0] next_i,  // older neighbour (rotate direction)
  output logic signed [SW-1:0] q_o
);

  logic signed [SW-1:0] q_r;
  logic signed [SW-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.shift) begin
      q_nxt = prev_i;
    end else if (ctl.rot) begin
      q_nxt = next_i;
    end
  end

  // contents undefined until written
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

`default_nettype wire

>>> rtl/wws_div.sv
// ----------------------------------------------------------------------------
// wws_div
// Division by a fixed divisor through reciprocal multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wws_div #(
  parameter int QW      = 16,    // quotient bits; dividend < DIVISOR << QW
  parameter int RW      = 14,    // bits of the divisor
  parameter int DIVISOR = 11101
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [QW+RW-1:0] dividend_i,
  output logic             busy_o,
  output logic [QW-1:0]    quot_o
);

  // ceil(2^SH / DIVISOR) is exact for every dividend below 2^NW, since the
  // rounding error of the reciprocal stays under DIVISOR < 2^RW
  localparam int NW = QW + RW;     // dividend bits
  localparam int SH = NW + RW;     // reciprocal scale
  localparam int MW = NW + 1;      // reciprocal bits
  localparam int PW = NW + MW;     // product bits
  localparam logic [SH:0]   SCALE   = (SH + 1)'(1) << SH;
  localparam logic [SH:0]   DIV_W   = (SH + 1)'(DIVISOR);
  localparam logic [SH:0]   RECIP_W = (SCALE + DIV_W - (SH + 1)'(1)) / DIV_W;
  localparam logic [MW-1:0] RECIP   = RECIP_W[MW-1:0];

  logic [NW-1:0] num_r, num_nxt;
  logic [QW-1:0] quot_r, quot_nxt;
  logic          busy_r, busy_nxt;
  logic [PW-1:0] prod_full;

  assign prod_full = PW'(num_r) * PW'(RECIP);

  always_comb begin
    num_nxt  = num_r;
    quot_nxt = quot_r;
    busy_nxt = start_i;
    if (start_i) begin
      num_nxt = dividend_i;
    end
    if (busy_r) begin
      quot_nxt = prod_full[SH+QW-1:SH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
  end

  assign busy_o = busy_r;
  assign quot_o = quot_r;

endmodule

`default_nettype wire

>>> rtl/wws_checker.sv
// ----------------------------------------------------------------------------
// wws_checker
// Port-level checks on the smoother, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_window_smoother_with_slope_macros.svh"

module wws_checker
  import wws_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((2*SAMPLE_WIDTH+1+BYTE_W-1)/BYTE_W)*BYTE_W-1:0] out_tdata,
  input logic out_tlast
);

  logic in_req;

  assign in_req = in_tvalid && in_tready;

  // out of reset: idle, nothing pending
  `WWS_ASSERT_IMP(a_reset_idle, $rose(rst_n), !out_tvalid && in_tready, "not idle after reset")

  // a stalled result holds
  `WWS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // a result takes a full ring pass; never appears the cycle after a request
  `WWS_ASSERT_NXT(a_no_instant, in_req && !out_tvalid, !out_tvalid, "result too early")

  // results are loaded only while the input side is busy
  `WWS_ASSERT_IMP(a_load_busy, $rose(out_tvalid), !$past(in_tready), "result loaded while idle")

endmodule

bind weighted_window_smoother_with_slope wws_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_wws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
